[hdl/irui_pkg.sv]
// shared types and constants for the id remap block
package irui_pkg;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_NEG = 2'd1;
  localparam logic [1:0] ST_CAP = 2'd2;

  localparam logic CFG_CAPACITY_LIMIT = 1'b0;
  localparam logic CFG_STRICT_LIMIT   = 1'b1;

  localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;

  typedef struct packed {
    logic [15:0] dense_index;
    logic [15:0] batch_position;
    logic        first_in_batch;
    logic        newly_assigned;
    logic [1:0]  status;
    logic        result_last;
    logic [16:0] unique_count;
  } result_t;

  typedef struct packed {
    logic [63:0] sparse_id;
    logic        batch_last;
  } item_t;

endpackage

[hdl/irui_if.sv]
// valid/ready channel interfaces
interface irui_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] sparse_id;
  logic        batch_last;
  modport source (output valid, sparse_id, batch_last, input ready);
  modport sink   (input valid, sparse_id, batch_last, output ready);
endinterface

interface irui_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] dense_index;
  logic [15:0] batch_position;
  logic        first_in_batch;
  logic        newly_assigned;
  logic [1:0]  status;
  logic        result_last;
  logic [16:0] unique_count;
  modport source (output valid, dense_index, batch_position, first_in_batch,
                  newly_assigned, status, result_last, unique_count, input ready);
  modport sink   (input valid, dense_index, batch_position, first_in_batch,
                  newly_assigned, status, result_last, unique_count, output ready);
endinterface

interface irui_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/irui_keymap.sv]
// key map memory: keys with valid, dense index per slot, registered read
module irui_keymap #(
  parameter int SLOT_W = 17,
  parameter int IDX_W  = 16
) (
  input  logic              clk,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [63:0]       rd_key,
  output logic              rd_valid,
  output logic [IDX_W-1:0]  rd_dense,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  logic [63:0]       wr_key,
  input  logic              wr_valid,
  input  logic [IDX_W-1:0]  wr_dense
);
  logic [64:0]      key_mem [2**SLOT_W];
  logic [IDX_W-1:0] idx_mem [2**SLOT_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= {wr_valid, wr_key};
      idx_mem[wr_addr] <= wr_dense;
    end
    {rd_valid, rd_key} <= key_mem[rd_addr];
    rd_dense <= idx_mem[rd_addr];
  end
endmodule

[hdl/irui_marks.sv]
// batch mark memory: tag and position per dense index, registered read
module irui_marks #(
  parameter int IDX_W = 16,
  parameter int POS_W = 16
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [7:0]       rd_tag,
  output logic [POS_W-1:0] rd_pos,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_tag,
  input  logic [POS_W-1:0] wr_pos
);
  logic [POS_W+7:0] mem [2**IDX_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_tag, wr_pos};
    end
    {rd_tag, rd_pos} <= mem[rd_addr];
  end
endmodule

[hdl/id_remap_unique_inverse_top.sv]
// top level of the sparse id to dense index remapper
//  channel  dir  ports                 word
//  in       in   in_valid/in_ready     sparse_id, batch_last
//  out      out  out_valid/out_ready   dense index, position, flags, count
//  cfg      in   cfg_valid/cfg_ready   register index, data
// after reset a clearing pass writes every key slot and mark entry empty;
//   no item is accepted meanwhile.
// a word passes accept, hash, key read, mark read and write back, and result load,
//   with an extra key read for each occupied slot that holds another key; the next
//   word is accepted only after result load. a negative id goes from accept to result load.
// the result sits in an output register; the next item is taken while it waits
//   and holds in its last step until out_ready frees the register.
// tag wraparound reruns the mark clearing pass.
module id_remap_unique_inverse_top #(
  parameter int SLOT_W = 17,
  parameter int IDX_W  = 16,
  parameter int POS_W  = 16
) (
  input logic clk,
  input logic rst_n,
  irui_in_if.sink    in_ch,
  irui_out_if.source out_ch,
  irui_cfg_if.sink   cfg_ch
);
  localparam int CLR_W = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_HASH = 3'd2,
                         S_PROBE = 3'd3, S_MARK = 3'd4, S_DONE = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CLR_W:0]    clr_r;
  logic              clr_keys_r;
  logic [63:0]       id_r;
  logic              last_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W:0]   probes_r;
  logic              found_r, full_r;
  logic [IDX_W-1:0]  dense_r;
  logic [16:0]       cap_r;
  logic              strict_r;
  logic [IDX_W:0]    next_idx_r;
  logic [POS_W:0]    count_r;
  logic [7:0]        tag_r;
  logic [SLOT_W-1:0] hash_lo_r, hash_x_r;
  irui_pkg::result_t acc_r;
  irui_pkg::result_t res_r;
  logic              res_v_r;

  logic [63:0]       k_key;
  logic              k_valid;
  logic [IDX_W-1:0]  k_dense;
  logic              k_wr;
  logic [SLOT_W-1:0] k_waddr, k_raddr;
  logic [7:0]        m_tag;
  logic [POS_W-1:0]  m_pos;
  logic              m_wr;
  logic [IDX_W-1:0]  m_waddr, m_raddr;
  logic [7:0]        m_wtag;
  logic [POS_W-1:0]  m_wpos;

  logic [SLOT_W-1:0] slot_inc;
  logic [IDX_W:0]    limit;
  logic              out_free;
  logic [63:0]       lo_prod;
  logic [SLOT_W-1:0] hash_cross;
  logic [SLOT_W-1:0] hash_slot;

  assign slot_inc = slot_r + SLOT_W'(1);
  assign out_free = !res_v_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // hash slot is the SLOT_W bits from bit 32 up of id * HASH_MUL, split into a 32x32 low product
  // and two narrow cross terms that only feed the kept bits
  assign lo_prod = 64'(in_ch.sparse_id[31:0]) * 64'(irui_pkg::HASH_MUL[31:0]);
  assign hash_cross = in_ch.sparse_id[SLOT_W-1:0] * irui_pkg::HASH_MUL[32 +: SLOT_W]
                    + in_ch.sparse_id[32 +: SLOT_W] * irui_pkg::HASH_MUL[SLOT_W-1:0];
  assign hash_slot = hash_lo_r + hash_x_r;

  always_comb begin
    limit = (IDX_W+1)'(1) << IDX_W;
    if (strict_r && ({{(IDX_W > 16 ? IDX_W-16 : 0){1'b0}}, cap_r} < limit))
      limit = (IDX_W+1)'(cap_r);
  end

  // read address: hash slot in the hash step, next slot on a probe mismatch, else the held slot
  assign k_raddr = (state_r == S_HASH) ? hash_slot :
                   (state_r == S_PROBE && k_valid && k_key != id_r) ? slot_inc : slot_r;

  irui_keymap #(.SLOT_W(SLOT_W), .IDX_W(IDX_W)) u_keymap (
    .clk, .rd_addr(k_raddr), .rd_key(k_key), .rd_valid(k_valid), .rd_dense(k_dense),
    .wr_en(k_wr), .wr_addr(k_waddr), .wr_key(id_r), .wr_valid(state_r != S_CLR),
    .wr_dense(next_idx_r[IDX_W-1:0]));

  irui_marks #(.IDX_W(IDX_W), .POS_W(POS_W)) u_marks (
    .clk, .rd_addr(m_raddr), .rd_tag(m_tag), .rd_pos(m_pos),
    .wr_en(m_wr), .wr_addr(m_waddr), .wr_tag(m_wtag), .wr_pos(m_wpos));

  logic miss_ok, batch_full, mark_hit;
  assign batch_full = count_r >= ((POS_W+1)'(1) << POS_W);
  assign mark_hit   = (m_tag == tag_r);
  assign miss_ok    = !full_r && (next_idx_r < limit) && !batch_full;

  always_comb begin
    state_nxt = state_r;
    k_wr = 1'b0; k_waddr = slot_r;
    m_wr = 1'b0; m_waddr = dense_r; m_wtag = tag_r; m_wpos = count_r[POS_W-1:0];
    m_raddr = dense_r;
    unique case (state_r)
      S_CLR: begin
        k_wr = clr_keys_r; k_waddr = clr_r[SLOT_W-1:0];
        m_wr = 1'b1; m_waddr = clr_r[IDX_W-1:0]; m_wtag = 8'd0;
        if (clr_r == (CLR_W+1)'((clr_keys_r ? (1 << CLR_W) : (1 << IDX_W)) - 1))
          state_nxt = S_IDLE;
      end
      S_IDLE:  if (in_ch.valid) state_nxt = in_ch.sparse_id[63] ? S_DONE : S_HASH;
      S_HASH:  state_nxt = S_PROBE;
      S_PROBE: begin
        m_raddr = k_dense;
        if (!k_valid || k_key == id_r || probes_r == (SLOT_W+1)'(1 << SLOT_W))
          state_nxt = S_MARK;
      end
      S_MARK: begin
        if (found_r) begin
          if (!mark_hit && !batch_full) m_wr = 1'b1;
        end else if (miss_ok) begin
          k_wr = 1'b1; m_wr = 1'b1; m_waddr = next_idx_r[IDX_W-1:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: if (out_free) state_nxt = (last_r && tag_r == 8'd255) ? S_CLR : S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; clr_keys_r <= 1'b1;
      cap_r <= 17'd65536; strict_r <= 1'b1;
      next_idx_r <= '0; count_r <= '0; tag_r <= 8'd1; res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        if (cfg_ch.index == irui_pkg::CFG_CAPACITY_LIMIT) cap_r <= cfg_ch.data;
        else strict_r <= cfg_ch.data[0];
      end
      if (state_r == S_DONE && out_free) res_v_r <= 1'b1;
      else if (out_ch.ready) res_v_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          if (state_nxt == S_IDLE) begin
            clr_r <= '0; clr_keys_r <= 1'b0;
          end else begin
            clr_r <= clr_r + 1'b1;
          end
        end
        S_IDLE: if (in_ch.valid) begin
          id_r <= in_ch.sparse_id; last_r <= in_ch.batch_last;
          hash_lo_r <= lo_prod[32 +: SLOT_W];
          hash_x_r  <= hash_cross;
          acc_r <= '{status: (in_ch.sparse_id[63] ? irui_pkg::ST_NEG : irui_pkg::ST_OK),
                     default: '0};
        end
        S_HASH: begin
          slot_r <= hash_slot; probes_r <= '0;
        end
        S_PROBE: begin
          found_r <= k_valid && k_key == id_r;
          full_r  <= k_valid && k_key != id_r;
          dense_r <= k_dense;
          if (k_valid && k_key != id_r) begin
            slot_r <= slot_inc; probes_r <= probes_r + 1'b1;
          end
        end
        S_MARK: begin
          if (found_r) begin
            if (mark_hit) begin
              acc_r <= '{dense_index: 16'(dense_r), batch_position: 16'(m_pos),
                         default: '0};
            end else if (batch_full) acc_r <= '{status: irui_pkg::ST_CAP, default: '0};
            else begin
              acc_r <= '{dense_index: 16'(dense_r), batch_position: 16'(count_r),
                         first_in_batch: 1'b1, default: '0};
              count_r <= count_r + 1'b1;
            end
          end else if (miss_ok) begin
            acc_r <= '{dense_index: 16'(next_idx_r), batch_position: 16'(count_r),
                       first_in_batch: 1'b1, newly_assigned: 1'b1, default: '0};
            count_r <= count_r + 1'b1; next_idx_r <= next_idx_r + 1'b1;
          end else acc_r <= '{status: irui_pkg::ST_CAP, default: '0};
        end
        S_DONE: if (out_free) begin
          res_r <= '{dense_index:    acc_r.dense_index,
                     batch_position: acc_r.batch_position,
                     first_in_batch: acc_r.first_in_batch,
                     newly_assigned: acc_r.newly_assigned,
                     status:         acc_r.status,
                     result_last:    last_r,
                     unique_count:   (last_r ? 17'(count_r) : 17'd0)};
          if (last_r) begin
            count_r <= '0;
            tag_r <= (tag_r == 8'd255) ? 8'd1 : tag_r + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid          = res_v_r;
  assign out_ch.dense_index    = res_r.dense_index;
  assign out_ch.batch_position = res_r.batch_position;
  assign out_ch.first_in_batch = res_r.first_in_batch;
  assign out_ch.newly_assigned = res_r.newly_assigned;
  assign out_ch.status         = res_r.status;
  assign out_ch.result_last    = res_r.result_last;
  assign out_ch.unique_count   = res_r.unique_count;

  a_no_accept_clr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_ch.ready) else $error("item taken during clear");
  a_tag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    tag_r != 8'd0) else $error("batch tag zero");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r && res_r.status != irui_pkg::ST_OK |-> res_r.dense_index == 16'd0
    && !res_r.first_in_batch) else $error("error result carries index");
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> next_idx_r >= $past(next_idx_r)) else $error("index moved back");
endmodule
